[sv/hse_pkg.sv]
package hse_pkg;

  // Default sizing of the sorter
  localparam int DEF_MAX_ELEMENTS = 64;
  localparam int DEF_VALUE_WIDTH  = 32;

  // Controls broadcast from the sequencer to every cell of the row
  typedef struct packed {
    logic load;   // insert the arriving element into the sorted row
    logic shift;  // advance the row one place towards the head
  } cell_ctrl_t;

endpackage

[sv/hse_cell.sv]
module hse_cell #(
  parameter int VALUE_WIDTH = hse_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hse_pkg::cell_ctrl_t           ctrl,
  input  logic signed [VALUE_WIDTH-1:0] new_value,
  input  logic signed [VALUE_WIDTH-1:0] prev_value,
  input  logic                          prev_valid,
  input  logic                          prev_keep,
  input  logic signed [VALUE_WIDTH-1:0] next_value,
  input  logic                          next_valid,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          valid,
  output logic                          keep
);

  // An empty cell counts as larger than anything
  assign keep = valid && (value <= new_value);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_value;
    end else if (ctrl.load && !keep) begin
      value <= prev_keep ? new_value : prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= next_valid;
    end else if (ctrl.load && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end
  end

endmodule

[sv/heap_sort_engine_unit.sv]
// Sorting engine for one set of signed values, smallest first.
//
// Input channel (in_valid / in_stall, fields value and is_last): each
// transfer inserts one element into a row of compare cells that is kept
// in ascending order at all times. A transfer with is_last set closes the
// set and starts the output run. Elements beyond MAX_ELEMENTS are dropped
// and every result of that run carries overflowed.
// Output channel (out_valid / out_stall, fields sorted_value, end_of_run,
// overflowed): one transfer per stored element, ascending, end_of_run on
// the largest one.
// Input elements are accepted back to back while loading. The first
// result is offered the cycle after the last element's transfer, then
// one result per cycle while out_stall is low. in_stall is high for the
// whole output run.
// A stalled result holds: the row only advances on an output transfer.
// Reset empties the row, clears the element count and the overflow flag
// and returns the block to loading.
module heap_sort_engine_unit #(
  parameter int MAX_ELEMENTS = hse_pkg::DEF_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = hse_pkg::DEF_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] sorted_value,
  output logic                          end_of_run,
  output logic                          overflowed
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  // Sequencer states
  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] count;
  logic             overflow_seen;

  logic in_fire;
  logic out_fire;
  logic full;
  logic store;

  hse_pkg::cell_ctrl_t ctrl;

  // Row of cells, head (smallest) at index 0
  logic signed [VALUE_WIDTH-1:0] cell_value [MAX_ELEMENTS];
  logic signed [VALUE_WIDTH-1:0] prev_value [MAX_ELEMENTS];
  logic signed [VALUE_WIDTH-1:0] next_value [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0]       cell_valid;
  logic [MAX_ELEMENTS-1:0]       cell_keep;
  logic [MAX_ELEMENTS-1:0]       prev_valid;
  logic [MAX_ELEMENTS-1:0]       prev_keep;
  logic [MAX_ELEMENTS-1:0]       next_valid;

  // Handshakes: take input only while loading
  assign in_stall  = (state == ST_DRAIN);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (state == ST_DRAIN) && cell_valid[0];
  assign out_fire  = out_valid && !out_stall;

  // Drop the element once the row is full
  assign full  = (count == CNT_W'(MAX_ELEMENTS));
  assign store = in_fire && !full;

  assign ctrl.load  = store;
  assign ctrl.shift = out_fire;

  // Result value comes straight from the head of the row; end_of_run marks an empty second cell
  assign sorted_value = cell_value[0];
  assign end_of_run   = !cell_valid[1];
  assign overflowed   = overflow_seen;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_fire && is_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && end_of_run) begin
          state_next = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (out_fire && end_of_run) begin
        // Run complete: ready for a fresh set
        count         <= '0;
        overflow_seen <= 1'b0;
      end else begin
        if (store) begin
          count <= count + CNT_W'(1);
        end
        if (in_fire && full) begin
          overflow_seen <= 1'b1;
        end
      end
    end
  end

  // Neighbour wiring: the head sees "everything before me is smaller",
  // the tail pulls in an empty slot when the row advances
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_value[i] = value;
      assign prev_valid[i] = 1'b0;
      assign prev_keep[i]  = 1'b1;
    end else begin : g_body
      assign prev_value[i] = cell_value[i-1];
      assign prev_valid[i] = cell_valid[i-1];
      assign prev_keep[i]  = cell_keep[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign next_value[i] = '0;
      assign next_valid[i] = 1'b0;
    end else begin : g_inner
      assign next_value[i] = cell_value[i+1];
      assign next_valid[i] = cell_valid[i+1];
    end

    hse_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .new_value (value),
      .prev_value(prev_value[i]),
      .prev_valid(prev_valid[i]),
      .prev_keep (prev_keep[i]),
      .next_value(next_value[i]),
      .next_valid(next_valid[i]),
      .value     (cell_value[i]),
      .valid     (cell_valid[i]),
      .keep      (cell_keep[i])
    );
  end

  // Occupied cells track the element count while loading
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ($countones(cell_valid) == int'(count)))
    else $error("occupied cells disagree with element count");

  // An output run never starts or stalls on an empty row
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> cell_valid[0])
    else $error("output run with empty head cell");

  // The two front cells stay in ascending order
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> (cell_value[0] <= cell_value[1]))
    else $error("row out of order at the head");

  // Final result transfer leaves the block empty and loading
  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    (out_fire && end_of_run) |=> (state == ST_LOAD && count == '0 && !overflow_seen))
    else $error("state not cleared after end of run");

endmodule

[tb/sv/heap_sort_engine_unit_tb.sv]
module heap_sort_engine_unit_tb;

  localparam int VW   = hse_pkg::DEF_VALUE_WIDTH;
  localparam int MAXE = hse_pkg::DEF_MAX_ELEMENTS;

  localparam logic signed [VW-1:0] MOST_NEG = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] MOST_POS = {1'b0, {(VW-1){1'b1}}};

  // Target number of input transfers over the whole run
  localparam int ITEM_TARGET = 410;
  // Receiver holds off once, after this many sets have closed
  localparam int HOLD_AFTER_SETS = 13;
  localparam int HOLD_CYCLES     = 300;

  // One result as the output channel presents it
  typedef struct packed {
    logic signed [VW-1:0] value;
    logic                 last;
    logic                 ovf;
  } sorted_result_t;

  // One row of directed stimulus; want is only used where typed is set
  typedef struct packed {
    logic signed [VW-1:0] val;
    bit                   last;
    bit                   typed;
    logic signed [VW-1:0] want;
  } stim_row_t;

  localparam int N_DIRECTED = 17;

  // Single-element sets come back unchanged, so their results are typed in.
  // The rest go through the predictor.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{MOST_NEG,         1'b1, 1'b1, MOST_NEG},
    '{MOST_POS,         1'b1, 1'b1, MOST_POS},
    '{32'sh0000_0000,   1'b1, 1'b1, 32'sh0000_0000},
    '{32'shffff_ffff,   1'b1, 1'b1, 32'shffff_ffff},
    // both extremes mixed with values around zero
    '{MOST_POS,         1'b0, 1'b0, '0},
    '{MOST_NEG,         1'b0, 1'b0, '0},
    '{32'sh0000_0000,   1'b0, 1'b0, '0},
    '{32'sh0000_0001,   1'b0, 1'b0, '0},
    '{32'shffff_ffff,   1'b1, 1'b0, '0},
    // equal values
    '{32'sh0000_0007,   1'b0, 1'b0, '0},
    '{32'sh0000_0007,   1'b0, 1'b0, '0},
    '{32'shffff_fff9,   1'b0, 1'b0, '0},
    '{32'sh0000_0007,   1'b1, 1'b0, '0},
    // descending pair
    '{32'sh4000_0000,   1'b0, 1'b0, '0},
    '{32'shc000_0000,   1'b1, 1'b0, '0},
    // alternating bit patterns
    '{32'sh5555_5555,   1'b0, 1'b0, '0},
    '{32'shaaaa_aaaa,   1'b1, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [VW-1:0] value = '0;
  logic                 is_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [VW-1:0] sorted_value;
  logic                 end_of_run;
  logic                 overflowed;

  heap_sort_engine_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .is_last      (is_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .end_of_run   (end_of_run),
    .overflowed   (overflowed)
  );

  always #1 clk = ~clk;

  // Predictor state: the elements of the open set, kept in ascending order,
  // and whether anything was dropped from it.
  logic signed [VW-1:0] loaded_vals [$];
  bit                   set_dropped;
  sorted_result_t       sorted_due [$];
  int                   sets_closed;
  int                   n_errors;
  bit                   calm;

  // Fold one accepted element into the open set; on a closing element,
  // queue the whole set ascending, or its typed result, and start a fresh one.
  function automatic void load_and_sort(input logic signed [VW-1:0] v, input bit last,
                                        input bit typed, input logic signed [VW-1:0] want);
    int             pos;
    sorted_result_t r;
    if (loaded_vals.size() < MAXE) begin
      pos = 0;
      while (pos < loaded_vals.size() && loaded_vals[pos] <= v) pos++;
      loaded_vals.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      if (typed) begin
        r = '{want, 1'b1, 1'b0};
        sorted_due.push_back(r);
      end else begin
        foreach (loaded_vals[i]) begin
          r = '{loaded_vals[i], i == loaded_vals.size() - 1, set_dropped};
          sorted_due.push_back(r);
        end
      end
      loaded_vals.delete();
      set_dropped = 1'b0;
      sets_closed++;
    end
  endfunction

  // Mix of extremes, small values around zero, repeats and full-range noise
  function automatic logic signed [VW-1:0] pick_value(input logic signed [VW-1:0] prev);
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return $signed($urandom_range(20)) - 10;
      3:       return prev;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element and hold it until the transfer completes. Entered and
  // left on a falling edge; random idle cycles go in front unless calm.
  task automatic offer_element(input logic signed [VW-1:0] v, input bit last,
                               input bit typed, input logic signed [VW-1:0] want);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    is_last  <= last;
    do @(posedge clk); while (in_stall);
    load_and_sort(v, last, typed, want);
    @(negedge clk);
  endtask

  // Receiver: stall at random, except for one long counted hold-off once
  // enough sets have closed, and no stalls at all while calm.
  initial begin : receiver
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sets_closed >= HOLD_AFTER_SETS) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 21);
      end
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin : result_check
    sorted_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        $error("unexpected result: sorted_value %0d end_of_run %0b overflowed %0b",
               sorted_value, end_of_run, overflowed);
        n_errors++;
      end else begin
        due = sorted_due.pop_front();
        if (sorted_value !== due.value) begin
          $error("sorted_value: expected %0d, got %0d", due.value, sorted_value);
          n_errors++;
        end
        if (end_of_run !== due.last) begin
          $error("end_of_run: expected %0b, got %0b", due.last, end_of_run);
          n_errors++;
        end
        if (overflowed !== due.ovf) begin
          $error("overflowed: expected %0b, got %0b", due.ovf, overflowed);
          n_errors++;
        end
      end
    end
  end

  // Sender: reset, directed table, then random sets
  initial begin : sender
    int                   sent;
    int                   set_no;
    int                   set_len;
    int                   roll;
    logic signed [VW-1:0] v;
    sent        = 0;
    set_no      = 0;
    v           = '0;
    n_errors    = 0;
    sets_closed = 0;
    set_dropped = 1'b0;
    calm        = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_element(directed_rows[i].val, directed_rows[i].last,
                    directed_rows[i].typed, directed_rows[i].want);
      sent++;
    end

    while (sent < ITEM_TARGET) begin
      // Force a few sets onto the capacity boundary: one that drops its
      // closing element, one exactly full, one dropping several.
      case (set_no)
        3:       set_len = MAXE + 1;
        7:       set_len = MAXE;
        12:      set_len = MAXE + 3;
        default: begin
          roll = $urandom_range(99);
          if (roll < 75)      set_len = $urandom_range(8, 1);
          else if (roll < 95) set_len = $urandom_range(24, 9);
          else                set_len = $urandom_range(40, 25);
        end
      endcase
      calm = (set_no >= 16 && set_no < 26);
      // Once, drain every outstanding result before the next set
      if (set_no == 9) begin
        in_valid <= 1'b0;
        do @(negedge clk); while (sorted_due.size() != 0);
      end
      for (int k = 0; k < set_len; k++) begin
        v = pick_value(v);
        offer_element(v, k == set_len - 1, 1'b0, '0);
        sent++;
      end
      set_no++;
    end
    calm     = 1'b0;
    in_valid <= 1'b0;

    while (sorted_due.size() != 0) @(negedge clk);
    // Keep the clock running to catch any stray result
    repeat (16) @(negedge clk);
    if (sorted_due.size() != 0) begin
      $error("%0d results never arrived", sorted_due.size());
      n_errors++;
    end
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard limit far beyond the slowest legal run
  initial begin : watchdog
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sim.f]
sv/hse_pkg.sv
sv/hse_cell.sv
sv/heap_sort_engine_unit.sv
tb/sv/heap_sort_engine_unit_tb.sv
